>>> sv/trc_pkg.sv
package trc_pkg;

  // Item command codes
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_DEV = 2'd0,
    CFG_ROUGH   = 2'd1,
    CFG_MEAN    = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_W     = 15;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] MAX_DEV_RST = 15'd410;
  localparam logic [CFG_W-1:0] ROUGH_RST   = 15'd205;
  localparam logic [CFG_W-1:0] MEAN_RST    = 15'd819;

  // Window shape
  localparam int unsigned WIN_ROWS  = 3;
  localparam int unsigned WIN_COLS  = 5;
  localparam int unsigned WIN_CELLS = WIN_ROWS * WIN_COLS;

  // Datapath widths
  localparam int unsigned H_W    = 16;  // height sample
  localparam int unsigned S_W    = 20;  // window sum, signed
  localparam int unsigned DIFF_W = 21;  // 15*v - S, signed
  localparam int unsigned DEV_W  = 20;  // |15*v - S|
  localparam int unsigned GSUM_W = 23;  // sum of one window row of deviations
  localparam int unsigned SUMD_W = 24;  // sum of all deviations
  localparam int unsigned NUM_W  = 27;  // cost numerator, signed
  localparam int unsigned MAG_W  = 26;  // numerator magnitude

  // Division by 225: q = (mag * RECIP_225) >> RECIP_SHIFT, exact for mag < 2**26
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned RECIP_SHIFT = 34;
  localparam int unsigned PROD_W      = MAG_W + RECIP_W;
  localparam int unsigned QUO_W       = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_225 = 27'd76354975;

  localparam logic signed [15:0] COST_BLOCKED = 16'sd4096;
  localparam logic signed [15:0] COST_MAX     = 16'sh7FFF;
  localparam logic signed [15:0] COST_MIN     = 16'sh8000;

  typedef struct packed {
    cmd_e              cmd;
    logic [6:0]        row;
    logic [6:0]        col;
    logic signed [15:0] height;
  } item_t;

  typedef struct packed {
    logic signed [15:0] cost;
    logic               blocked;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_LANE,
    ST_GROUP,
    ST_SUM,
    ST_NUM,
    ST_MAG,
    ST_MUL,
    ST_FIN
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic wr_en;
    logic load;
    logic rd_en;
    logic lane_en;
    logic grp_en;
    logic sum_en;
    logic num_en;
    logic mag_en;
    logic mul_en;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic rd_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/terrain_roughness_cost.sv
// Query: the result follows fifteen window reads through the single map read port
//   plus the drain, reduction, divide and output stages; no new item is accepted
//   until the result has been loaded into the output register.
// Write: one item per cycle while idle, no result.
// Reset: control clears at once, then a clearing pass zeroes the map one cell a cycle,
//   covering all ROWS*COLS cells (16384 by default); no item is accepted until it ends.
module terrain_roughness_cost #(
  parameter int ROWS = 128,
  parameter int COLS = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  trc_pkg::item_t                 in_item_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output trc_pkg::result_t               out_item_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [trc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [trc_pkg::CFG_W-1:0]      cfg_data_i
);

  // The controller sequences one item at a time:
  //   clear sweep after reset, then idle; a write item lands in the map on the
  //   accept edge; a query item walks the 3x5 window (fifteen reads, one a cycle),
  //   drains the last read, forms the fifteen deviations in parallel lanes,
  //   reduces them through a two-level registered tree, builds the thresholds
  //   and the cost numerator, takes its magnitude, divides by 225 with a
  //   reciprocal multiply and finally truncates, saturates and loads the output
  //   register.
  // The output register parts the two sides: the next item is taken while a
  // result still waits to be accepted; only the final stage holds when the
  // register is still full.

  trc_pkg::dp_cmd_t  dp_cmd;
  trc_pkg::dp_stat_t dp_stat;

  trc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_item_i.cmd),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Datapath: height map memory, limit registers, window sum, lanes, tree, divider
  trc_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> sv/trc_dp.sv
module trc_dp #(
  parameter int ROWS = 128,
  parameter int COLS = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  trc_pkg::dp_cmd_t                   cmd_i,
  output trc_pkg::dp_stat_t                  stat_o,
  input  trc_pkg::item_t                     in_item_i,
  input  logic                               cfg_we_i,
  input  logic [trc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [trc_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output trc_pkg::result_t                   out_item_o
);

  localparam int Depth = ROWS * COLS;
  localparam int AW    = $clog2(Depth);

  // Configuration registers
  logic [trc_pkg::CFG_W-1:0] max_dev_q, rough_q, mean_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dev_q <= trc_pkg::MAX_DEV_RST;
      rough_q   <= trc_pkg::ROUGH_RST;
      mean_q    <= trc_pkg::MEAN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        trc_pkg::CFG_MAX_DEV: max_dev_q <= cfg_data_i;
        trc_pkg::CFG_ROUGH:   rough_q   <= cfg_data_i;
        trc_pkg::CFG_MEAN:    mean_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clear sweep counter
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // Query cell and window walk
  logic [6:0] row_q, col_q;
  logic [1:0] ro_q;
  logic [2:0] co_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ro_q <= '0;
      co_q <= '0;
    end else if (cmd_i.load) begin
      ro_q <= '0;
      co_q <= '0;
    end else if (cmd_i.rd_en) begin
      if (co_q == 3'(trc_pkg::WIN_COLS - 1)) begin
        co_q <= '0;
        ro_q <= ro_q + 2'd1;
      end else begin
        co_q <= co_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q <= in_item_i.row;
      col_q <= in_item_i.col;
    end
  end

  logic signed [8:0] win_r, win_c;
  logic              win_in_grid;
  logic [AW-1:0]     rd_addr;

  assign win_r = $signed({2'b00, row_q}) + $signed({7'b0000000, ro_q}) - 9'sd1;
  assign win_c = $signed({2'b00, col_q}) + $signed({6'b000000, co_q}) - 9'sd2;
  assign win_in_grid = !win_r[8] && !win_c[8] && (int'(win_r) < ROWS) &&
                       (int'(win_c) < COLS);
  assign rd_addr = AW'(int'(win_r) * COLS + int'(win_c));

  // Item write address
  logic          wr_in_grid;
  logic [AW-1:0] wr_addr;

  assign wr_in_grid = (int'(in_item_i.row) < ROWS) && (int'(in_item_i.col) < COLS);
  assign wr_addr    = AW'(int'(in_item_i.row) * COLS + int'(in_item_i.col));

  // Height map: one write port, one registered read port
  logic [trc_pkg::H_W-1:0] map_mem [Depth];
  logic [trc_pkg::H_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      map_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.wr_en && wr_in_grid) begin
      map_mem[wr_addr] <= in_item_i.height;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= map_mem[rd_addr];
    end
  end

  logic rd_vld_q, rd_oob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_oob_q <= !win_in_grid;
  end

  // Collect window cells and their sum
  logic signed [trc_pkg::H_W-1:0] v_in;
  logic signed [trc_pkg::H_W-1:0] v_q [trc_pkg::WIN_CELLS];
  logic signed [trc_pkg::S_W-1:0] s_q;

  assign v_in = rd_oob_q ? '0 : $signed(rd_data_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q <= '0;
    end else if (rd_vld_q) begin
      s_q <= s_q + trc_pkg::S_W'(v_in);
    end
    if (rd_vld_q) begin
      for (int k = 0; k < trc_pkg::WIN_CELLS - 1; k++) begin
        v_q[k] <= v_q[k+1];
      end
      v_q[trc_pkg::WIN_CELLS-1] <= v_in;
    end
  end

  // Deviation lanes
  logic signed [trc_pkg::DIFF_W-1:0] diff [trc_pkg::WIN_CELLS];
  logic [trc_pkg::DEV_W-1:0]         dev_d [trc_pkg::WIN_CELLS];
  logic [trc_pkg::DEV_W-1:0]         dev_q [trc_pkg::WIN_CELLS];
  logic signed [trc_pkg::NUM_W-1:0]  s15_q;

  always_comb begin
    for (int k = 0; k < trc_pkg::WIN_CELLS; k++) begin
      diff[k] = (trc_pkg::DIFF_W'(v_q[k]) <<< 4) - trc_pkg::DIFF_W'(v_q[k]) -
                trc_pkg::DIFF_W'(s_q);
      dev_d[k] = diff[k][trc_pkg::DIFF_W-1] ? trc_pkg::DEV_W'(-diff[k])
                                            : trc_pkg::DEV_W'(diff[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lane_en) begin
      for (int k = 0; k < trc_pkg::WIN_CELLS; k++) begin
        dev_q[k] <= dev_d[k];
      end
      s15_q <= (trc_pkg::NUM_W'(s_q) <<< 4) - trc_pkg::NUM_W'(s_q);
    end
  end

  // Reduction tree: one node per window row, then the total
  logic [trc_pkg::GSUM_W-1:0] gsum_d [trc_pkg::WIN_ROWS];
  logic [trc_pkg::DEV_W-1:0]  gmax_d [trc_pkg::WIN_ROWS];
  logic [trc_pkg::GSUM_W-1:0] gsum_q [trc_pkg::WIN_ROWS];
  logic [trc_pkg::DEV_W-1:0]  gmax_q [trc_pkg::WIN_ROWS];

  always_comb begin
    for (int g = 0; g < trc_pkg::WIN_ROWS; g++) begin
      gsum_d[g] = '0;
      gmax_d[g] = '0;
      for (int j = 0; j < trc_pkg::WIN_COLS; j++) begin
        gsum_d[g] = gsum_d[g] + trc_pkg::GSUM_W'(dev_q[g*trc_pkg::WIN_COLS+j]);
        if (dev_q[g*trc_pkg::WIN_COLS+j] > gmax_d[g]) begin
          gmax_d[g] = dev_q[g*trc_pkg::WIN_COLS+j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grp_en) begin
      for (int g = 0; g < trc_pkg::WIN_ROWS; g++) begin
        gsum_q[g] <= gsum_d[g];
        gmax_q[g] <= gmax_d[g];
      end
    end
  end

  logic [trc_pkg::SUMD_W-1:0] sumd_d, sumd_q;
  logic [trc_pkg::DEV_W-1:0]  maxd_d, maxd_q;

  always_comb begin
    sumd_d = '0;
    maxd_d = '0;
    for (int g = 0; g < trc_pkg::WIN_ROWS; g++) begin
      sumd_d = sumd_d + trc_pkg::SUMD_W'(gsum_q[g]);
      if (gmax_q[g] > maxd_d) begin
        maxd_d = gmax_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      sumd_q <= sumd_d;
      maxd_q <= maxd_d;
    end
  end

  // Thresholds and cost numerator
  logic [18:0]                      lim_dev, lim_mean;
  logic [22:0]                      lim_rough;
  logic                             blk_d, blk_q;
  logic signed [trc_pkg::NUM_W-1:0] num_d, num_q;

  assign lim_dev   = 19'(max_dev_q) * 19'd15;
  assign lim_rough = 23'(rough_q) * 23'd225;
  assign lim_mean  = 19'(mean_q) * 19'd15;

  assign blk_d = (maxd_q > 20'(lim_dev)) || (sumd_q > 24'(lim_rough)) ||
                 (s_q > $signed({1'b0, lim_mean}));

  assign num_d = $signed({3'b000, maxd_q, 4'b0000}) - $signed({7'b0000000, maxd_q}) +
                 $signed({2'b00, sumd_q, 1'b0}) + s15_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.num_en) begin
      num_q <= num_d;
      blk_q <= blk_d;
    end
  end

  // Magnitude, then division by 225 through the reciprocal
  logic [trc_pkg::MAG_W-1:0]  mag_q;
  logic                       neg_q;
  logic [trc_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag_en) begin
      mag_q <= num_q[trc_pkg::NUM_W-1] ? trc_pkg::MAG_W'(-num_q) : trc_pkg::MAG_W'(num_q);
      neg_q <= num_q[trc_pkg::NUM_W-1];
    end
    if (cmd_i.mul_en) begin
      prod_q <= mag_q * trc_pkg::RECIP_225;
    end
  end

  // Truncate toward zero, saturate, select blocked cost
  logic [trc_pkg::QUO_W-1:0] quo;
  logic signed [15:0]        sat_cost;
  trc_pkg::result_t          res_d;

  always_comb begin
    quo = prod_q[trc_pkg::RECIP_SHIFT +: trc_pkg::QUO_W];
    if (neg_q) begin
      sat_cost = (quo >= trc_pkg::QUO_W'(32768)) ? trc_pkg::COST_MIN
                                                 : $signed(16'(trc_pkg::QUO_W'(0) - quo));
    end else begin
      sat_cost = (quo > trc_pkg::QUO_W'(32767)) ? trc_pkg::COST_MAX : $signed(quo[15:0]);
    end
    res_d.cost    = blk_q ? trc_pkg::COST_BLOCKED : sat_cost;
    res_d.blocked = blk_q;
  end

  // Output register
  logic             out_valid_q;
  trc_pkg::result_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign stat_o.clr_last = (clr_cnt_q == AW'(Depth - 1));
  assign stat_o.rd_last  = (ro_q == 2'(trc_pkg::WIN_ROWS - 1)) &&
                           (co_q == 3'(trc_pkg::WIN_COLS - 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unaccepted result");

  a_reads_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lane_en |-> !rd_vld_q)
    else $error("deviation lanes started before the last window read landed");

  a_load_restarts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (ro_q == 2'd0) && (co_q == 3'd0) && (s_q == '0))
    else $error("query did not restart the window walk");

endmodule

>>> sv/trc_ctrl.sv
module trc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  trc_pkg::cmd_e      in_cmd_i,
  output logic               in_ready_o,
  input  trc_pkg::dp_stat_t  stat_i,
  output trc_pkg::dp_cmd_t   cmd_o
);

  trc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      trc_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_last) begin
          state_d = trc_pkg::ST_IDLE;
        end
      end
      trc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == trc_pkg::CMD_QUERY) begin
            cmd_o.load = 1'b1;
            state_d    = trc_pkg::ST_READ;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      trc_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        if (stat_i.rd_last) begin
          state_d = trc_pkg::ST_DRAIN;
        end
      end
      trc_pkg::ST_DRAIN: state_d = trc_pkg::ST_LANE;
      trc_pkg::ST_LANE: begin
        cmd_o.lane_en = 1'b1;
        state_d       = trc_pkg::ST_GROUP;
      end
      trc_pkg::ST_GROUP: begin
        cmd_o.grp_en = 1'b1;
        state_d      = trc_pkg::ST_SUM;
      end
      trc_pkg::ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = trc_pkg::ST_NUM;
      end
      trc_pkg::ST_NUM: begin
        cmd_o.num_en = 1'b1;
        state_d      = trc_pkg::ST_MAG;
      end
      trc_pkg::ST_MAG: begin
        cmd_o.mag_en = 1'b1;
        state_d      = trc_pkg::ST_MUL;
      end
      trc_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = trc_pkg::ST_FIN;
      end
      trc_pkg::ST_FIN: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = trc_pkg::ST_IDLE;
        end
      end
      default: state_d = trc_pkg::ST_CLEAR;
    endcase
  end

  a_port_users_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr_en, cmd_o.wr_en, cmd_o.rd_en, cmd_o.out_load}))
    else $error("map port or output register driven by two operations");

  a_query_starts_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_cmd_i == trc_pkg::CMD_QUERY)) |=>
      (state_q == trc_pkg::ST_READ))
    else $error("accepted query did not start the window reads");

  a_last_read_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == trc_pkg::ST_READ) && stat_i.rd_last) |=> (state_q == trc_pkg::ST_DRAIN))
    else $error("window reads did not stop after the last cell");

endmodule

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Grid size matches the block's default parameters
  localparam int ROWS = 128;
  localparam int COLS = 128;

  // Settle time after the last result, since a write may still be in flight then.
  localparam int SETTLE_CYC  = 48;
  localparam int HOLD_CYC    = 600;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 118;
  localparam int MAX_GAP     = 10;

  localparam trc_pkg::result_t RES_ZERO = '{cost: 16'sd0, blocked: 1'b0};
  localparam trc_pkg::result_t RES_BLK  = '{cost: trc_pkg::COST_BLOCKED, blocked: 1'b1};
  localparam trc_pkg::result_t RES_NONE = '0;

  typedef struct {
    trc_pkg::item_t   it;
    bit               typed;
    trc_pkg::result_t res;
  } dir_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  trc_pkg::item_t   in_item   = '0;
  logic             in_ready;
  logic             out_valid;
  logic             out_ready = 1'b0;
  trc_pkg::result_t out_item;
  logic                          cfg_we   = 1'b0;
  logic [trc_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [trc_pkg::CFG_W-1:0]     cfg_data = '0;

  // Shadow copy of the map and limits, kept in step with accepted items
  logic signed [15:0]        heights [ROWS][COLS];
  logic [trc_pkg::CFG_W-1:0] dev_lim   = trc_pkg::MAX_DEV_RST;
  logic [trc_pkg::CFG_W-1:0] rough_lim = trc_pkg::ROUGH_RST;
  logic [trc_pkg::CFG_W-1:0] mean_lim  = trc_pkg::MEAN_RST;

  trc_pkg::result_t pending_costs [$];
  dir_row_t         dir_rows [$];
  int               mismatches   = 0;
  int               results_seen = 0;
  bit               hold_req     = 1'b0;

  // Per-phase shaping of the random items
  int plateau;
  int base_r;
  int base_c;

  terrain_roughness_cost #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset low from the start, release it on a rising edge
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Run limit: the clearing pass plus every item at its slowest, several times over
  initial begin
    #4_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic trc_pkg::item_t mk_item(trc_pkg::cmd_e cmd, int r, int c, int h);
    trc_pkg::item_t it;
    it.cmd    = cmd;
    it.row    = 7'(r);
    it.col    = 7'(c);
    it.height = 16'(h);
    return it;
  endfunction

  // Append one row to the directed table
  task automatic add_row(trc_pkg::item_t it, bit typed, trc_pkg::result_t res);
    dir_row_t row;
    row.it    = it;
    row.typed = typed;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Append one expected result behind those already waiting
  task automatic queue_cost(trc_pkg::result_t res);
    pending_costs.insert(pending_costs.size(), res);
  endtask

  // Cost of the 3x5 window centred on (r, c); cells off the grid read as zero.
  // Deviations are scaled by the cell count (15) so everything stays integer.
  function automatic trc_pkg::result_t window_cost(logic [6:0] r, logic [6:0] c);
    longint           v [15];
    longint           s;
    longint           maxd;
    longint           sumd;
    longint           d;
    longint           num;
    int               rr;
    int               cc;
    bit               blk;
    trc_pkg::result_t res;
    s    = 0;
    maxd = 0;
    sumd = 0;
    for (int k = 0; k < 15; k++) begin
      rr = int'(r) - 1 + k / 5;
      cc = int'(c) - 2 + k % 5;
      if (rr >= 0 && rr < ROWS && cc >= 0 && cc < COLS) begin
        v[k] = longint'(heights[rr][cc]);
      end else begin
        v[k] = 0;
      end
      s += v[k];
    end
    for (int k = 0; k < 15; k++) begin
      d = 15 * v[k] - s;
      if (d < 0) begin
        d = -d;
      end
      sumd += d;
      if (d > maxd) begin
        maxd = d;
      end
    end
    blk = (maxd > 15 * longint'(dev_lim)) ||
          (sumd > 225 * longint'(rough_lim)) ||
          (s > 15 * longint'(mean_lim));
    if (blk) begin
      res.cost = trc_pkg::COST_BLOCKED;
    end else begin
      // SystemVerilog division truncates toward zero, as required
      num = (15 * maxd + 2 * sumd + 15 * s) / 225;
      if (num > 32767) begin
        num = 32767;
      end
      if (num < -32768) begin
        num = -32768;
      end
      res.cost = 16'(num);
    end
    res.blocked = blk;
    return res;
  endfunction

  // Offer one item after an optional gap, hold it until accepted, then
  // update the shadow map or queue the expected cost.
  task automatic offer_item(trc_pkg::item_t it, int gap, bit typed,
                            trc_pkg::result_t typed_res);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.cmd == trc_pkg::CMD_WRITE) begin
      heights[it.row][it.col] = it.height;
    end else if (typed) begin
      queue_cost(typed_res);
    end else begin
      queue_cost(window_cost(it.row, it.col));
    end
  endtask

  // Drop valid, wait for every expected cost, then let any trailing write finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(trc_pkg::cfg_idx_e idx, logic [trc_pkg::CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      trc_pkg::CFG_MAX_DEV: dev_lim = val;
      trc_pkg::CFG_ROUGH:   rough_lim = val;
      default:              mean_lim = val;
    endcase
  endtask

  task automatic set_limits(int dev, int rough, int mean);
    write_reg(trc_pkg::CFG_MAX_DEV, trc_pkg::CFG_W'(dev));
    write_reg(trc_pkg::CFG_ROUGH, trc_pkg::CFG_W'(rough));
    write_reg(trc_pkg::CFG_MEAN, trc_pkg::CFG_W'(mean));
    cfg_we <= 1'b0;
  endtask

  // Result side: stall a random number of cycles per item, with eager bursts
  // and one long hold-off on request so the block backs up into its input.
  initial begin
    int               stall;
    trc_pkg::result_t exp;
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYC;
        hold_req = 1'b0;
      end else if (results_seen % 50 < 12) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (pending_costs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cost %0d blocked %0b",
                 $time, out_item.cost, out_item.blocked);
        mismatches++;
      end else begin
        exp = pending_costs.pop_front();
        if (out_item.cost !== exp.cost) begin
          $display("%0t: cost mismatch, expected %0d, actual %0d",
                   $time, exp.cost, out_item.cost);
          mismatches++;
        end
        if (out_item.blocked !== exp.blocked) begin
          $display("%0t: blocked mismatch, expected %0b, actual %0b",
                   $time, exp.blocked, out_item.blocked);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed table first, then random phases under several limit settings
  initial begin
    trc_pkg::item_t it;
    trc_pkg::cmd_e  cmd;
    int             r;
    int             c;
    int             h;
    int             sel;
    int             gap;

    foreach (heights[i, j]) begin
      heights[i][j] = '0;
    end

    // Empty map reads zero everywhere, corners included
    add_row(mk_item(trc_pkg::CMD_QUERY, 0, 0, 0), 1'b1, RES_ZERO);
    add_row(mk_item(trc_pkg::CMD_QUERY, 127, 127, -1), 1'b1, RES_ZERO);
    // Extreme heights: a lone peak or pit blocks under the reset limits
    add_row(mk_item(trc_pkg::CMD_WRITE, 64, 64, 32767), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 64, 64, 0), 1'b1, RES_BLK);
    add_row(mk_item(trc_pkg::CMD_WRITE, 64, 64, -32768), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 64, 64, 0), 1'b1, RES_BLK);
    add_row(mk_item(trc_pkg::CMD_WRITE, 64, 64, 0), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 64, 64, 0), 1'b1, RES_ZERO);
    // Bumps near the edges and one interior cell: windows hanging off the grid and inside it
    add_row(mk_item(trc_pkg::CMD_WRITE, 0, 0, 100), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_WRITE, 1, 2, -50), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_WRITE, 127, 127, 4095), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_WRITE, 127, 0, -1), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_WRITE, 10, 10, -7), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 0, 0, 0), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 1, 1, 0), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 127, 127, 0), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 126, 1, 0), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 127, 0, 0), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 0, 127, 0), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 10, 10, 0), 1'b0, RES_NONE);
    add_row(mk_item(trc_pkg::CMD_QUERY, 11, 12, 0), 1'b0, RES_NONE);

    // Hold off until reset is released; the handshake covers the clearing pass
    while (!rst_n) @(posedge clk);

    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].it, $urandom_range(0, MAX_GAP), dir_rows[i].typed,
                 dir_rows[i].res);
    end
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      // Sweep the limits: all open, all shut, reset values, then random
      case (p)
        0:       set_limits(32767, 32767, 32767);
        1:       set_limits(0, 0, 0);
        2:       set_limits(trc_pkg::MAX_DEV_RST, trc_pkg::ROUGH_RST, trc_pkg::MEAN_RST);
        5:       set_limits($urandom_range(0, 32767), $urandom_range(0, 32767),
                            $urandom_range(0, 32767));
        default: set_limits($urandom_range(0, 4000), $urandom_range(0, 2000),
                            $urandom_range(0, 4000));
      endcase

      // Concentrate traffic on a small patch so queries see filled windows;
      // alternate between the top-left corner, the bottom-right corner and anywhere.
      plateau = int'($urandom_range(0, 65535)) - 32768;
      case (p % 3)
        0: begin
          base_r = 0;
          base_c = 0;
        end
        1: begin
          base_r = ROWS - 5;
          base_c = COLS - 7;
        end
        default: begin
          base_r = $urandom_range(0, ROWS - 5);
          base_c = $urandom_range(0, COLS - 7);
        end
      endcase

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Stall the result side for a long stretch while items keep coming
        if (p == 3 && i == 40) begin
          hold_req = 1'b1;
        end
        if ($urandom_range(0, 9) < 6) begin
          r = base_r + $urandom_range(0, 4);
          c = base_c + $urandom_range(0, 6);
        end else begin
          r = $urandom_range(0, ROWS - 1);
          c = $urandom_range(0, COLS - 1);
        end
        // Mix a shared plateau (near-uniform windows), small bumps, medium bumps, and full range
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          h = plateau;
        end else if (sel < 65) begin
          h = int'($urandom_range(0, 800)) - 400;
        end else if (sel < 80) begin
          h = int'($urandom_range(0, 8192)) - 4096;
        end else begin
          h = int'($urandom_range(0, 65535)) - 32768;
        end
        if ($urandom_range(0, 99) < 55) begin
          cmd = trc_pkg::CMD_WRITE;
        end else begin
          cmd = trc_pkg::CMD_QUERY;
        end
        it  = mk_item(cmd, r, c, h);
        // Back-to-back at the start of each phase, random gaps after
        gap = (i < 25) ? 0 : $urandom_range(0, MAX_GAP);
        offer_item(it, gap, 1'b0, RES_NONE);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
